@@ hw/rtl/hstm_pkg.sv @@
// shared types, constants and codes of the hard-sphere trial move block
`default_nettype none

package hstm_pkg;

    // store geometry
    localparam int MAX_PARTICLES = 1024;
    localparam int IDX_W         = $clog2(MAX_PARTICLES);
    localparam int CNT_W         = $clog2(MAX_PARTICLES + 1);

    // field widths
    localparam int POS_W  = 24;
    localparam int VAL_W  = POS_W + 1;
    localparam int WRAP_W = POS_W + 3;
    localparam int SQ_W   = 2 * POS_W;
    localparam int SUM_W  = SQ_W + 2;

    // configuration port
    localparam int ADDR_W = 6;
    localparam int DATA_W = 64;

    // reset values of the configuration registers
    localparam logic [POS_W-1:0] BOX_RESET     = 24'd655360;
    localparam logic [SQ_W-1:0]  OVERLAP_RESET = 48'h0001_0000_0000;

    // register index, taken from paddr[5:3]
    typedef enum logic [2:0] {
        REG_BOX_X   = 3'd0,
        REG_BOX_Y   = 3'd1,
        REG_BOX_Z   = 3'd2,
        REG_COUNT   = 3'd3,
        REG_OVERLAP = 3'd4
    } reg_idx_t;

    // operation codes of an input transaction
    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_MOVE = 1'b1
    } op_t;

    // status codes of a result transaction
    typedef enum logic [1:0] {
        ST_REJECT = 2'd0,
        ST_ACCEPT = 2'd1,
        ST_LOADED = 2'd2,
        ST_BAD    = 2'd3
    } status_t;

    // configuration register contents
    typedef struct packed {
        logic [POS_W-1:0] box_x;
        logic [POS_W-1:0] box_y;
        logic [POS_W-1:0] box_z;
        logic [CNT_W-1:0] particle_count;
        logic [SQ_W-1:0]  overlap_dist_sq;
    } cfg_t;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic load_wr;
        logic wrap_a;
        logic wrap_b;
        logic scan_en;
        logic commit;
        logic out_load;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic bad;
        logic is_move;
        logic scan_last;
        logic pipe_busy;
    } sts_t;

    // controller states
    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_DECODE = 10'b00_0000_0010,
        S_LOAD   = 10'b00_0000_0100,
        S_OWN_RD = 10'b00_0000_1000,
        S_WRAP_A = 10'b00_0001_0000,
        S_WRAP_B = 10'b00_0010_0000,
        S_SCAN   = 10'b00_0100_0000,
        S_DRAIN  = 10'b00_1000_0000,
        S_COMMIT = 10'b01_0000_0000,
        S_FINISH = 10'b10_0000_0000
    } state_t;

endpackage

`default_nettype wire

@@ hw/rtl/hstm_cfg_regs.sv @@
// configuration register file behind the APB-style port
`default_nettype none

module hstm_cfg_regs
    import hstm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    logic     wr_en;
    reg_idx_t wr_idx;
    cfg_t     cfg_reg;
    cfg_t     cfg_next;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign wr_idx = reg_idx_t'(paddr[ADDR_W-1:3]);
    assign cfg    = cfg_reg;

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_idx)
                REG_BOX_X:   cfg_next.box_x           = pwdata[POS_W-1:0];
                REG_BOX_Y:   cfg_next.box_y           = pwdata[POS_W-1:0];
                REG_BOX_Z:   cfg_next.box_z           = pwdata[POS_W-1:0];
                REG_COUNT:   cfg_next.particle_count  = pwdata[CNT_W-1:0];
                REG_OVERLAP: cfg_next.overlap_dist_sq = pwdata[SQ_W-1:0];
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.box_x           <= BOX_RESET;
            cfg_reg.box_y           <= BOX_RESET;
            cfg_reg.box_z           <= BOX_RESET;
            cfg_reg.particle_count  <= '0;
            cfg_reg.overlap_dist_sq <= OVERLAP_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // read back
    always_comb
    begin
        case (wr_idx)
            REG_BOX_X:   prdata = DATA_W'(cfg_reg.box_x);
            REG_BOX_Y:   prdata = DATA_W'(cfg_reg.box_y);
            REG_BOX_Z:   prdata = DATA_W'(cfg_reg.box_z);
            REG_COUNT:   prdata = DATA_W'(cfg_reg.particle_count);
            REG_OVERLAP: prdata = DATA_W'(cfg_reg.overlap_dist_sq);
            default:     prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

@@ hw/rtl/hstm_ctrl.sv @@
// sequencing state machine of the trial move block
`default_nettype none

module hstm_ctrl
    import hstm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    output logic out_valid,
    input  logic out_stall,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (sts.bad)
                begin
                    state_next = S_FINISH;
                end
                else if (sts.is_move)
                begin
                    state_next = S_OWN_RD;
                end
                else
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                cmd.load_wr = 1'b1;
                state_next  = S_FINISH;
            end
            S_OWN_RD:
            begin
                state_next = S_WRAP_A;
            end
            S_WRAP_A:
            begin
                cmd.wrap_a = 1'b1;
                state_next = S_WRAP_B;
            end
            S_WRAP_B:
            begin
                cmd.wrap_b = 1'b1;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.scan_en = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!sts.pipe_busy)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                // output register free or being emptied this cycle
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/hstm_datapath.sv @@
// position store, wrap logic and the pipelined overlap scan
`default_nettype none

module hstm_datapath
    import hstm_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  cmd_t                    cmd,
    output sts_t                    sts,
    input  cfg_t                    cfg,
    input  logic                    operation,
    input  logic [IDX_W-1:0]        particle_index,
    input  logic signed [VAL_W-1:0] value_x,
    input  logic signed [VAL_W-1:0] value_y,
    input  logic signed [VAL_W-1:0] value_z,
    output logic [1:0]              status,
    output logic [POS_W-1:0]        pos_x,
    output logic [POS_W-1:0]        pos_y,
    output logic [POS_W-1:0]        pos_z
);

    typedef logic [2:0][POS_W-1:0]  vec_t;
    typedef logic [2:0][VAL_W-1:0]  dvec_t;
    typedef logic [2:0][WRAP_W-1:0] wvec_t;
    typedef logic [2:0][SQ_W-1:0]   sqvec_t;

    // position store, one word holds x, y and z
    vec_t mem [MAX_PARTICLES];

    op_t              op_reg;
    logic [IDX_W-1:0] idx_reg;
    dvec_t            val_reg;
    logic             bad_reg;
    logic             bad_next;

    vec_t             box_v;
    logic [CNT_W-1:0] count_eff;
    logic [CNT_W-1:0] count_m1;
    vec_t             load_v;

    logic [IDX_W-1:0] raddr;
    logic             mem_we;
    vec_t             wdata;
    vec_t             rdata_reg;

    vec_t             own_reg;
    wvec_t            p_reg;
    wvec_t            p_next;
    vec_t             trial_reg;
    vec_t             trial_next;

    logic [IDX_W-1:0] scan_cnt_reg;
    logic             v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    vec_t             d_reg, d_next;
    vec_t             f_reg, f_next;
    sqvec_t           sq_reg, sq_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic             hit_reg;

    logic [1:0]       status_reg;
    vec_t             pos_reg;

    assign box_v     = {cfg.box_z, cfg.box_y, cfg.box_x};
    assign count_eff = (cfg.particle_count > CNT_W'(MAX_PARTICLES)) ?
                       CNT_W'(MAX_PARTICLES) : cfg.particle_count;
    assign count_m1  = count_eff - CNT_W'(1);
    assign bad_next  = ({1'b0, particle_index} >= count_eff);

    // status toward the controller
    assign sts.bad       = bad_reg;
    assign sts.is_move   = (op_reg == OP_MOVE);
    assign sts.scan_last = ({1'b0, scan_cnt_reg} == count_m1);
    assign sts.pipe_busy = v1_reg || v2_reg || v3_reg || v4_reg || v5_reg;

    // input transaction capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= op_t'(operation);
            idx_reg <= particle_index;
            val_reg <= {value_z, value_y, value_x};
            bad_reg <= bad_next;
        end
    end

    // load values, negative saturates to zero
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            load_v[a] = val_reg[a][VAL_W-1] ? '0 : val_reg[a][POS_W-1:0];
        end
    end

    // store access
    assign raddr  = cmd.scan_en ? scan_cnt_reg : idx_reg;
    assign mem_we = cmd.load_wr || (cmd.commit && !hit_reg);
    assign wdata  = cmd.load_wr ? load_v : trial_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[idx_reg] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    // trial position: add displacement, then wrap once and saturate
    always_comb
    begin
        logic [WRAP_W-1:0] bw;
        logic [WRAP_W-1:0] q;
        for (int a = 0; a < 3; a++)
        begin
            p_next[a] = {3'b000, rdata_reg[a]} + {{2{val_reg[a][VAL_W-1]}}, val_reg[a]};
        end
        for (int a = 0; a < 3; a++)
        begin
            bw = {3'b000, box_v[a]};
            if ($signed(p_reg[a]) > $signed(bw))
            begin
                q = p_reg[a] - bw;
            end
            else if (p_reg[a][WRAP_W-1])
            begin
                q = p_reg[a] + bw;
            end
            else
            begin
                q = p_reg[a];
            end
            if (q[WRAP_W-1])
            begin
                trial_next[a] = '0;
            end
            else if (|q[WRAP_W-2:POS_W])
            begin
                trial_next[a] = '1;
            end
            else
            begin
                trial_next[a] = q[POS_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wrap_a)
        begin
            own_reg <= rdata_reg;
            p_reg   <= p_next;
        end
        if (cmd.wrap_b)
        begin
            trial_reg <= trial_next;
        end
    end

    // scan stages: abs difference, nearest-image fold, square, sum
    always_comb
    begin
        logic [POS_W:0] diff;
        logic [POS_W:0] e;
        logic           far;
        for (int a = 0; a < 3; a++)
        begin
            diff = {1'b0, rdata_reg[a]} - {1'b0, trial_reg[a]};
            d_next[a] = diff[POS_W] ? (trial_reg[a] - rdata_reg[a]) : diff[POS_W-1:0];
        end
        for (int a = 0; a < 3; a++)
        begin
            far = ({d_reg[a], 1'b0} > {1'b0, box_v[a]});
            e   = {1'b0, box_v[a]} - {1'b0, d_reg[a]};
            if (!far)
            begin
                f_next[a] = d_reg[a];
            end
            else if (e[POS_W])
            begin
                f_next[a] = d_reg[a] - box_v[a];
            end
            else
            begin
                f_next[a] = e[POS_W-1:0];
            end
        end
        for (int a = 0; a < 3; a++)
        begin
            sq_next[a] = f_reg[a] * f_reg[a];
        end
        sum_next = SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
    end

    always_ff @(posedge clk)
    begin
        d_reg   <= d_next;
        f_reg   <= f_next;
        sq_reg  <= sq_next;
        sum_reg <= sum_next;
    end

    // scan control: index counter, stage valid tags and the overlap flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_cnt_reg <= '0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            v4_reg       <= 1'b0;
            v5_reg       <= 1'b0;
            hit_reg      <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.scan_en && (scan_cnt_reg != idx_reg);
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            if (cmd.wrap_b)
            begin
                scan_cnt_reg <= '0;
                hit_reg      <= 1'b0;
            end
            else
            begin
                if (cmd.scan_en)
                begin
                    scan_cnt_reg <= scan_cnt_reg + IDX_W'(1);
                end
                if (v5_reg && (sum_reg < SUM_W'(cfg.overlap_dist_sq)))
                begin
                    hit_reg <= 1'b1;
                end
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            if (bad_reg)
            begin
                status_reg <= ST_BAD;
                pos_reg    <= '0;
            end
            else if (op_reg == OP_LOAD)
            begin
                status_reg <= ST_LOADED;
                pos_reg    <= load_v;
            end
            else if (hit_reg)
            begin
                status_reg <= ST_REJECT;
                pos_reg    <= own_reg;
            end
            else
            begin
                status_reg <= ST_ACCEPT;
                pos_reg    <= trial_reg;
            end
        end
    end

    assign status = status_reg;
    assign pos_x  = pos_reg[0];
    assign pos_y  = pos_reg[1];
    assign pos_z  = pos_reg[2];

endmodule

`default_nettype wire

@@ hw/rtl/hard_sphere_trial_move.sv @@
// Hard-sphere Monte Carlo trial move with a 3D periodic overlap check.
//
// Input channel (in_valid/in_stall) carries one transaction per load or move;
// output channel (out_valid/out_stall) returns exactly one result for each.
// Positions and displacements are Q8.16; boxes, particle_count and the
// squared contact distance are set through the APB-style port; the user must
// set them only while idle, which the block itself does not enforce. The
// block handles one transaction at a time and stalls its input until the
// result has been placed in the output register. Particles in use number
// min(particle_count, 1024), and an index at or above that count is bad:
// the result carries status ST_BAD and a zero position, and the position
// store is left unchanged.
// A move scans every particle in use, one stored position per cycle through
// the single read port of the position store, then drains a five-stage
// distance pipeline; that scan sets the move throughput.
// Reset initializes the controller and configuration registers; the position
// store is not cleared and every entry must be loaded before a move reads it.
// A stalled result holds in the output register, and the next transaction
// can be accepted and worked on meanwhile; it waits only to be written out.
`default_nettype none

module hard_sphere_trial_move
    import hstm_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [ADDR_W-1:0]       paddr,
    input  logic [DATA_W-1:0]       pwdata,
    output logic [DATA_W-1:0]       prdata,
    output logic                    pready,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    operation,
    input  logic [IDX_W-1:0]        particle_index,
    input  logic signed [VAL_W-1:0] value_x,
    input  logic signed [VAL_W-1:0] value_y,
    input  logic signed [VAL_W-1:0] value_z,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [1:0]              status,
    output logic [POS_W-1:0]        pos_x,
    output logic [POS_W-1:0]        pos_y,
    output logic [POS_W-1:0]        pos_z
);

    cfg_t cfg;
    cmd_t cmd;
    sts_t sts;

    // configuration registers
    hstm_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sequencer
    hstm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // store and arithmetic
    hstm_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .cfg            (cfg),
        .operation      (operation),
        .particle_index (particle_index),
        .value_x        (value_x),
        .value_y        (value_y),
        .value_z        (value_z),
        .status         (status),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .pos_z          (pos_z)
    );

endmodule

`default_nettype wire

@@ hw/rtl/hstm_checker.sv @@
// port-level checks of the trial move block, bound to the top level
`default_nettype none

module hstm_checker
    import hstm_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_stall,
    input logic             out_valid,
    input logic             out_stall,
    input logic [1:0]       status,
    input logic [POS_W-1:0] pos_x,
    input logic [POS_W-1:0] pos_y,
    input logic [POS_W-1:0] pos_z
);

    // a stalled result stays valid
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(status) && $stable(pos_x)
                                   && $stable(pos_y) && $stable(pos_z))
        else $error("result payload changed while stalled");

    // one transaction in flight: input stalls right after an acceptance
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second transaction accepted while busy");

    // a bad index reports a zero position
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_BAD) |-> (pos_x == '0) && (pos_y == '0)
                                            && (pos_z == '0))
        else $error("bad index result with nonzero position");

endmodule

bind hard_sphere_trial_move hstm_checker u_hstm_checker (.*);

`default_nettype wire

@@ tb/sv/hard_sphere_trial_move_test.sv @@
// self-checking testbench of the hard-sphere trial move block: directed table, random phases
`timescale 1ns / 100ps

module hard_sphere_trial_move_test;

    import hstm_pkg::*;

    localparam int ONE             = 65536;
    localparam int MAXV            = 16777215;
    localparam int MINV            = -8388608;
    localparam int N_DIRECTED      = 20;
    localparam int N_PHASES        = 12;
    localparam int ITEMS_PER_PHASE = 42;
    localparam int HOLD_CYCLES     = 300;
    localparam int SETTLE_CYCLES   = 8;
    localparam int FINAL_SETTLE    = 1100;
    localparam int DRAIN_LIMIT     = 20000;

    // one result transaction
    typedef struct {
        status_t          code;
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic [POS_W-1:0] z;
    } move_result_t;

    typedef enum bit {
        ROW_ITEM,
        ROW_WRITE
    } row_kind_t;

    // one row of the directed table
    typedef struct {
        row_kind_t    kind;
        op_t          op;
        int           idx;
        int           vx;
        int           vy;
        int           vz;
        reg_idx_t     reg_sel;
        logic [63:0]  reg_value;
        bit           typed;
        move_result_t want;
    } directed_row_t;

    logic                    clk            = 1'b0;
    logic                    rst_n          = 1'b0;
    logic                    psel           = 1'b0;
    logic                    penable        = 1'b0;
    logic                    pwrite         = 1'b0;
    logic [ADDR_W-1:0]       paddr          = '0;
    logic [DATA_W-1:0]       pwdata         = '0;
    logic [DATA_W-1:0]       prdata;
    logic                    pready;
    logic                    in_valid       = 1'b0;
    logic                    in_stall;
    logic                    operation      = 1'b0;
    logic [IDX_W-1:0]        particle_index = '0;
    logic signed [VAL_W-1:0] value_x        = '0;
    logic signed [VAL_W-1:0] value_y        = '0;
    logic signed [VAL_W-1:0] value_z        = '0;
    logic                    out_valid;
    logic                    out_stall      = 1'b0;
    logic [1:0]              status;
    logic [POS_W-1:0]        pos_x;
    logic [POS_W-1:0]        pos_y;
    logic [POS_W-1:0]        pos_z;

    // predicted particle store and register copies
    logic [POS_W-1:0] stored_x [MAX_PARTICLES];
    logic [POS_W-1:0] stored_y [MAX_PARTICLES];
    logic [POS_W-1:0] stored_z [MAX_PARTICLES];
    bit               entry_loaded [MAX_PARTICLES];
    logic [POS_W-1:0] shadow_box_x   = BOX_RESET;
    logic [POS_W-1:0] shadow_box_y   = BOX_RESET;
    logic [POS_W-1:0] shadow_box_z   = BOX_RESET;
    logic [CNT_W-1:0] shadow_count   = '0;
    logic [SQ_W-1:0]  shadow_overlap = OVERLAP_RESET;

    move_result_t  pending_outcomes [$];
    move_result_t  blank_outcome;
    directed_row_t directed_rows [N_DIRECTED];
    int            mismatch_count = 0;
    int            hold_requests  = 0;
    bit            source_calm    = 1'b0;
    bit            sink_calm      = 1'b0;

    hard_sphere_trial_move i_dut (.*);

    always #5 clk = ~clk;

    // run limit
    initial
    begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t mismatch %s: got %0h expected %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    // negative load values clamp to zero
    function automatic logic [POS_W-1:0] clamp_load(logic signed [VAL_W-1:0] v);
        if (v < 0)
            return '0;
        return v[POS_W-1:0];
    endfunction

    // add displacement, wrap once into the box, saturate
    function automatic logic [POS_W-1:0] wrap_coord(logic [POS_W-1:0] old,
                                                    logic signed [VAL_W-1:0] disp,
                                                    logic [POS_W-1:0] box);
        longint p;
        longint b;
        b = longint'(box);
        p = longint'(old) + longint'(disp);
        if (p > b)
            p -= b;
        if (p < 0)
            p += b;
        if (p < 0)
            p = 0;
        if (p > longint'(MAXV))
            p = longint'(MAXV);
        return p[POS_W-1:0];
    endfunction

    // nearest-image squared distance along one axis
    function automatic longint axis_sq(logic [POS_W-1:0] a, logic [POS_W-1:0] b,
                                       logic [POS_W-1:0] box);
        longint d;
        d = longint'(a) - longint'(b);
        if (d < 0)
            d = -d;
        if (2 * d > longint'(box))
            d = longint'(box) - d;
        return d * d;
    endfunction

    // expected outcome of one transaction, updates the predicted store
    function automatic move_result_t predict_trial_move(op_t op, logic [IDX_W-1:0] idx,
                                                        logic signed [VAL_W-1:0] vx,
                                                        logic signed [VAL_W-1:0] vy,
                                                        logic signed [VAL_W-1:0] vz);
        move_result_t     r;
        int               n;
        int               i;
        bit               hit;
        longint           dr;
        logic [POS_W-1:0] nx;
        logic [POS_W-1:0] ny;
        logic [POS_W-1:0] nz;
        n = (shadow_count > MAX_PARTICLES) ? MAX_PARTICLES : int'(shadow_count);
        if (int'(idx) >= n)
        begin
            r = '{ST_BAD, 24'd0, 24'd0, 24'd0};
            return r;
        end
        if (op == OP_LOAD)
        begin
            stored_x[idx]     = clamp_load(vx);
            stored_y[idx]     = clamp_load(vy);
            stored_z[idx]     = clamp_load(vz);
            entry_loaded[idx] = 1'b1;
            r = '{ST_LOADED, stored_x[idx], stored_y[idx], stored_z[idx]};
            return r;
        end
        nx  = wrap_coord(stored_x[idx], vx, shadow_box_x);
        ny  = wrap_coord(stored_y[idx], vy, shadow_box_y);
        nz  = wrap_coord(stored_z[idx], vz, shadow_box_z);
        hit = 1'b0;
        // scan every other particle in use, stop at the first overlap
        for (i = 0; i < n && !hit; i++)
        begin
            if (i != int'(idx))
            begin
                dr = axis_sq(stored_x[i], nx, shadow_box_x)
                   + axis_sq(stored_y[i], ny, shadow_box_y)
                   + axis_sq(stored_z[i], nz, shadow_box_z);
                if (dr < longint'(shadow_overlap))
                    hit = 1'b1;
            end
        end
        if (!hit)
        begin
            stored_x[idx] = nx;
            stored_y[idx] = ny;
            stored_z[idx] = nz;
        end
        r = '{hit ? ST_REJECT : ST_ACCEPT, stored_x[idx], stored_y[idx], stored_z[idx]};
        return r;
    endfunction

    // a move may only scan entries that were loaded
    function automatic bit scan_safe(int n);
        int i;
        for (i = 0; i < n; i++)
            if (!entry_loaded[i])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic int rand_value();
        return int'($urandom_range(0, MAXV - MINV)) + MINV;
    endfunction

    function automatic int load_coord(logic [POS_W-1:0] box);
        if ($urandom_range(0, 99) < 85)
            return int'($urandom_range(0, box));
        return rand_value();
    endfunction

    function automatic int step_coord(logic [POS_W-1:0] box);
        int m;
        m = int'(box) / 4 + 16;
        if ($urandom_range(0, 99) < 85)
            return int'($urandom_range(0, 2 * m)) - m;
        return rand_value();
    endfunction

    // sender gap length, mostly short
    function automatic int pick_gap();
        int roll;
        if (source_calm)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        if (roll < 98)
            return $urandom_range(4, 20);
        return $urandom_range(30, 80);
    endfunction

    // offer one transaction, predict it once accepted
    task automatic send_item(op_t op, int idx, int vx, int vy, int vz,
                             bit typed, move_result_t want);
        move_result_t outcome;
        int           gap;
        operation      <= op;
        particle_index <= idx[IDX_W-1:0];
        value_x        <= vx[VAL_W-1:0];
        value_y        <= vy[VAL_W-1:0];
        value_z        <= vz[VAL_W-1:0];
        in_valid       <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        outcome = predict_trial_move(op, idx[IDX_W-1:0], vx[VAL_W-1:0], vy[VAL_W-1:0],
                                     vz[VAL_W-1:0]);
        pending_outcomes.push_back(typed ? want : outcome);
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_outcomes_drained();
        int waited;
        waited = 0;
        while (pending_outcomes.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
    endtask

    // stop offering and let the block go idle
    task automatic settle_input();
        in_valid <= 1'b0;
        wait_outcomes_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // apb write: setup then access
    task automatic write_reg(reg_idx_t sel, logic [63:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 3'b000};
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (sel)
            REG_BOX_X:   shadow_box_x   = v[POS_W-1:0];
            REG_BOX_Y:   shadow_box_y   = v[POS_W-1:0];
            REG_BOX_Z:   shadow_box_z   = v[POS_W-1:0];
            REG_COUNT:   shadow_count   = v[CNT_W-1:0];
            REG_OVERLAP: shadow_overlap = v[SQ_W-1:0];
            default:     ;
        endcase
    endtask

    function automatic int phase_count(int ph);
        case (ph)
            0:       return 2;
            1:       return 8;
            2:       return MAX_PARTICLES;
            3:       return 0;
            4:       return 16;
            5:       return 1;
            6:       return 64;
            7:       return 5;
            8:       return 32;
            9:       return 3;
            10:      return 12;
            default: return 2;
        endcase
    endfunction

    // new register setting for a phase, boxes and contact distance included
    task automatic configure_phase(int ph);
        logic [POS_W-1:0] bx;
        logic [POS_W-1:0] by;
        logic [POS_W-1:0] bz;
        logic [SQ_W-1:0]  ov;
        longint           d;
        bx = $urandom_range(2 * ONE, 40 * ONE);
        by = $urandom_range(2 * ONE, 40 * ONE);
        bz = $urandom_range(2 * ONE, 40 * ONE);
        case (ph)
            1:       begin bx = '1; by = '1; bz = '1; end
            4:       begin bx = '0; by = '0; bz = '0; end
            7:       begin bx = '1; by = '0; bz = ONE; end
            default: ;
        endcase
        d  = $urandom_range(0, int'(bx) / 3 + 16);
        ov = d * d;
        case (ph)
            5, 9:    ov = '1;
            10:      ov = '0;
            default: ;
        endcase
        settle_input();
        write_reg(REG_BOX_X, bx);
        write_reg(REG_BOX_Y, by);
        write_reg(REG_BOX_Z, bz);
        write_reg(REG_COUNT, phase_count(ph));
        write_reg(REG_OVERLAP, ov);
    endtask

    // below MAX_PARTICLES load the missing entries, then mostly moves, some loads and bad indexes
    task automatic run_phase(int ph);
        int n;
        int k;
        int roll;
        source_calm = (ph % 4 == 1);
        sink_calm   = (ph % 4 == 2);
        configure_phase(ph);
        n = phase_count(ph);
        if (n < MAX_PARTICLES)
            for (k = 0; k < n; k++)
                if (!entry_loaded[k])
                    send_item(OP_LOAD, k, load_coord(shadow_box_x), load_coord(shadow_box_y),
                              load_coord(shadow_box_z), 1'b0, blank_outcome);
        for (k = 0; k < ITEMS_PER_PHASE; k++)
        begin
            // receiver holds off while the sender keeps offering
            if (ph == 1 && k == 10)
                hold_requests++;
            // sender pauses until every result is back
            if (ph == 6 && k == 20)
            begin
                in_valid <= 1'b0;
                wait_outcomes_drained();
            end
            roll = $urandom_range(0, 99);
            if (n == 0 || (roll < 12 && n < MAX_PARTICLES))
                send_item(op_t'($urandom_range(0, 1)), $urandom_range(n, MAX_PARTICLES - 1),
                          rand_value(), rand_value(), rand_value(), 1'b0, blank_outcome);
            else if (roll < 30 || !scan_safe(n))
                send_item(OP_LOAD, $urandom_range(0, n - 1), load_coord(shadow_box_x),
                          load_coord(shadow_box_y), load_coord(shadow_box_z), 1'b0,
                          blank_outcome);
            else
                send_item(OP_MOVE, $urandom_range(0, n - 1), step_coord(shadow_box_x),
                          step_coord(shadow_box_y), step_coord(shadow_box_z), 1'b0,
                          blank_outcome);
        end
    endtask

    // result side: check accepted transactions, drive random stalls
    always @(posedge clk)
    begin : result_side
        int roll;
        int hold_served;
        int hold_left;
        int stall_left;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_outcomes.size() == 0)
                report_mismatch("result with nothing expected", status, 0);
            else
            begin
                if (status !== pending_outcomes[0].code)
                    report_mismatch("status", status, pending_outcomes[0].code);
                if (pos_x !== pending_outcomes[0].x)
                    report_mismatch("pos_x", pos_x, pending_outcomes[0].x);
                if (pos_y !== pending_outcomes[0].y)
                    report_mismatch("pos_y", pos_y, pending_outcomes[0].y);
                if (pos_z !== pending_outcomes[0].z)
                    report_mismatch("pos_z", pos_z, pending_outcomes[0].z);
                void'(pending_outcomes.pop_front());
            end
        end
        if (hold_served != hold_requests)
        begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (sink_calm)
            out_stall <= 1'b0;
        else
        begin
            roll = $urandom_range(0, 99);
            if (roll < 70)
                out_stall <= 1'b0;
            else
            begin
                stall_left = (roll < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
                out_stall <= 1'b1;
            end
        end
    end

    // main sequence
    initial
    begin
        int k;
        int ph;
        blank_outcome = '{ST_REJECT, 24'd0, 24'd0, 24'd0};
        directed_rows = '{
            // bad index with no particles in use
            '{ROW_ITEM, OP_LOAD, 0, 0, 0, 0, REG_COUNT, 64'd0, 1'b1,
              '{ST_BAD, 24'd0, 24'd0, 24'd0}},
            '{ROW_ITEM, OP_MOVE, 1023, MAXV, MINV, 1, REG_COUNT, 64'd0, 1'b1,
              '{ST_BAD, 24'd0, 24'd0, 24'd0}},
            '{ROW_WRITE, OP_LOAD, 0, 0, 0, 0, REG_COUNT, 64'd4, 1'b0, blank_outcome},
            // negative loads clamp, largest loads pass
            '{ROW_ITEM, OP_LOAD, 0, -1, MINV, -ONE, REG_COUNT, 64'd0, 1'b1,
              '{ST_LOADED, 24'd0, 24'd0, 24'd0}},
            '{ROW_ITEM, OP_LOAD, 1, MAXV, MAXV, MAXV, REG_COUNT, 64'd0, 1'b1,
              '{ST_LOADED, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF}},
            '{ROW_ITEM, OP_LOAD, 2, 5 * ONE, 5 * ONE, 5 * ONE, REG_COUNT, 64'd0, 1'b1,
              '{ST_LOADED, 24'd327680, 24'd327680, 24'd327680}},
            '{ROW_ITEM, OP_LOAD, 3, 2 * ONE, 5 * ONE, 5 * ONE, REG_COUNT, 64'd0, 1'b1,
              '{ST_LOADED, 24'd131072, 24'd327680, 24'd327680}},
            '{ROW_ITEM, OP_LOAD, 4, ONE, ONE, ONE, REG_COUNT, 64'd0, 1'b1,
              '{ST_BAD, 24'd0, 24'd0, 24'd0}},
            // approach particle 2: clear, touching, then inside contact
            '{ROW_ITEM, OP_MOVE, 3, ONE, 0, 0, REG_COUNT, 64'd0, 1'b0, blank_outcome},
            '{ROW_ITEM, OP_MOVE, 3, ONE, 0, 0, REG_COUNT, 64'd0, 1'b0, blank_outcome},
            '{ROW_ITEM, OP_MOVE, 3, 1, 0, 0, REG_COUNT, 64'd0, 1'b0, blank_outcome},
            // wrap past the box and below zero
            '{ROW_ITEM, OP_MOVE, 2, MAXV, 0, 0, REG_COUNT, 64'd0, 1'b0, blank_outcome},
            '{ROW_ITEM, OP_MOVE, 0, MINV, MINV, MINV, REG_COUNT, 64'd0, 1'b0, blank_outcome},
            // zero box saturates both ways
            '{ROW_WRITE, OP_LOAD, 0, 0, 0, 0, REG_BOX_Z, 64'd0, 1'b0, blank_outcome},
            '{ROW_ITEM, OP_MOVE, 1, 0, 0, MAXV, REG_COUNT, 64'd0, 1'b0, blank_outcome},
            '{ROW_ITEM, OP_MOVE, 2, 0, 0, MINV, REG_COUNT, 64'd0, 1'b0, blank_outcome},
            // contact distance extremes
            '{ROW_WRITE, OP_LOAD, 0, 0, 0, 0, REG_OVERLAP, 64'd0, 1'b0, blank_outcome},
            '{ROW_ITEM, OP_MOVE, 3, 1, 1, 1, REG_COUNT, 64'd0, 1'b0, blank_outcome},
            '{ROW_WRITE, OP_LOAD, 0, 0, 0, 0, REG_OVERLAP, 64'hFFFF_FFFF_FFFF, 1'b0,
              blank_outcome},
            '{ROW_ITEM, OP_MOVE, 0, ONE, ONE, ONE, REG_COUNT, 64'd0, 1'b0, blank_outcome}
        };

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed table
        for (k = 0; k < N_DIRECTED; k++)
        begin
            if (directed_rows[k].kind == ROW_WRITE)
            begin
                settle_input();
                write_reg(directed_rows[k].reg_sel, directed_rows[k].reg_value);
            end
            else
                send_item(directed_rows[k].op, directed_rows[k].idx, directed_rows[k].vx,
                          directed_rows[k].vy, directed_rows[k].vz, directed_rows[k].typed,
                          directed_rows[k].want);
        end

        // random phases
        for (ph = 0; ph < N_PHASES; ph++)
            run_phase(ph);

        // drain and finish
        in_valid <= 1'b0;
        wait_outcomes_drained();
        repeat (FINAL_SETTLE) @(posedge clk);
        if (pending_outcomes.size() != 0)
            report_mismatch("results missing at end", pending_outcomes.size(), 0);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
